[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the polar sampler checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, off during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

// condition that must hold while reset is asserted
`define ASSERT_IN_RESET(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) (!rst_n) |-> (cond)) \
        else $error("assertion failed: reset state");

`endif

[hw/rtl/pus_pkg.sv]
// ----------------------------------------------------------------------------
// pus_pkg
// Shared constants, codes and types of the polar unwarp sampler.
// ----------------------------------------------------------------------------
package pus_pkg;

    // store geometry
    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;
    localparam int MAX_ANGLES = 2048;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int ANG_W = $clog2(MAX_ANGLES);

    // image store is split in four banks by row and column parity
    localparam int NUM_BANKS  = 4;
    localparam int BANK_SEL_W = 2;
    localparam int BANK_DEPTH = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2);

    // field widths
    localparam int REQ_W    = 2;
    localparam int RAD_W    = 9;
    localparam int PIX_W    = 8;
    localparam int TRIG_W   = 16;
    localparam int SIZE_W   = 10;
    localparam int CTR_W    = 18;
    localparam int FRAC_W   = 9;
    localparam int Q8_SHIFT = 8;
    localparam int TRIG_SHIFT = 6;   // Q.14 product down to Q.8

    // datapath widths
    localparam int DIST_W  = RAD_W + 1;
    localparam int PROD_W  = DIST_W + 1 + TRIG_W;
    localparam int COORD_W = PROD_W - TRIG_SHIFT + 2;
    localparam int BASE_W  = COORD_W - Q8_SHIFT;
    localparam int LERP_W  = PIX_W + FRAC_W;
    localparam int SUM_W   = LERP_W + FRAC_W;

    localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1 << Q8_SHIFT);
    localparam logic [PIX_W-1:0]  PIX_MAX  = '1;

    // queues
    localparam int MID_DEPTH = 8;
    localparam int MID_PW    = $clog2(MID_DEPTH);
    localparam int MID_CW    = MID_PW + 1;
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PW    = $clog2(OUT_DEPTH);
    localparam int OUT_CW    = OUT_PW + 1;

    // request codes
    localparam logic [REQ_W-1:0] REQ_PIXEL  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TRIG   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = CTR_W;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_RADIUS = 3'd4;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(512);

    // effective configuration seen by the front end
    typedef struct packed {
        logic [SIZE_W-1:0] width;    // clamped to 2..MAX_WIDTH
        logic [SIZE_W-1:0] height;   // clamped to 2..MAX_HEIGHT
        logic [CTR_W-1:0]  center_x;
        logic [CTR_W-1:0]  center_y;
        logic [RAD_W-1:0]  inner;
    } cfg_t;

    // one queued operation: pixel write or classified sample
    typedef struct packed {
        logic              is_sample;
        logic [COL_W-1:0]  col;      // write column or base column
        logic [ROW_W-1:0]  row;      // write row or base row
        logic [FRAC_W-1:0] fx;
        logic [FRAC_W-1:0] fy;
        logic [PIX_W-1:0]  value;
        logic [RAD_W-1:0]  rad;
        logic [ANG_W-1:0]  ang;
    } qentry_t;

endpackage

[hw/rtl/pus_ram.sv]
// ----------------------------------------------------------------------------
// pus_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pus_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/pus_front.sv]
// ----------------------------------------------------------------------------
// pus_front
// Accepts requests, owns the trig tables and turns samples into base
// indexes and fractions; pixel writes ride along in order.
// ----------------------------------------------------------------------------
module pus_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [pus_pkg::REQ_W-1:0]  req_type,
    input  logic [pus_pkg::COL_W-1:0]  pixel_col,
    input  logic [pus_pkg::ROW_W-1:0]  pixel_row,
    input  logic [pus_pkg::PIX_W-1:0]  pixel_value,
    input  logic [pus_pkg::ANG_W-1:0]  angle_index,
    input  logic signed [pus_pkg::TRIG_W-1:0] cos_value,
    input  logic signed [pus_pkg::TRIG_W-1:0] sin_value,
    input  logic [pus_pkg::RAD_W-1:0]  radius_index,
    input  pus_pkg::cfg_t              cfg,
    input  logic [pus_pkg::MID_CW-1:0] q_cnt,
    output logic                       q_push,
    output pus_pkg::qentry_t           q_data
);
    import pus_pkg::*;

    typedef struct packed {
        logic [SIZE_W-1:0] base;
        logic [FRAC_W-1:0] frac;
    } axis_t;

    // clamp base to 0..size-2 and fraction to 0..1
    function automatic axis_t axis_map(input logic signed [COORD_W-1:0] c,
                                       input logic [SIZE_W-1:0] size);
        logic signed [BASE_W-1:0] p;
        logic [BASE_W-2:0]        pu;
        logic [SIZE_W-1:0]        lim;
        axis_t                    r;
        p   = c[COORD_W-1:Q8_SHIFT];
        pu  = p[BASE_W-2:0];
        lim = size - SIZE_W'(2);
        if (p[BASE_W-1])
        begin
            r.base = '0;
            r.frac = '0;
        end
        else if (pu > (BASE_W-1)'(lim))
        begin
            r.base = lim;
            r.frac = FRAC_ONE;
        end
        else
        begin
            r.base = pu[SIZE_W-1:0];
            r.frac = {1'b0, c[Q8_SHIFT-1:0]};
        end
        return r;
    endfunction

    logic accept;
    logic [MID_CW:0] busy;
    logic [TRIG_W-1:0] cos_rdata;
    logic [TRIG_W-1:0] sin_rdata;

    // stage 1: after table read
    logic                s1_valid_reg;
    logic                s1_sample_reg;
    logic [COL_W-1:0]    s1_col_reg;
    logic [ROW_W-1:0]    s1_row_reg;
    logic [PIX_W-1:0]    s1_value_reg;
    logic [RAD_W-1:0]    s1_rad_reg;
    logic [ANG_W-1:0]    s1_ang_reg;
    logic [DIST_W-1:0]   s1_dist_reg;

    // stage 2: after multiply
    logic                s2_valid_reg;
    logic                s2_sample_reg;
    logic [COL_W-1:0]    s2_col_reg;
    logic [ROW_W-1:0]    s2_row_reg;
    logic [PIX_W-1:0]    s2_value_reg;
    logic [RAD_W-1:0]    s2_rad_reg;
    logic [ANG_W-1:0]    s2_ang_reg;
    logic signed [PROD_W-1:0] s2_px_reg;
    logic signed [PROD_W-1:0] s2_py_reg;

    // stage 3: Q.8 coordinates
    logic                s3_valid_reg;
    logic                s3_sample_reg;
    logic [COL_W-1:0]    s3_col_reg;
    logic [ROW_W-1:0]    s3_row_reg;
    logic [PIX_W-1:0]    s3_value_reg;
    logic [RAD_W-1:0]    s3_rad_reg;
    logic [ANG_W-1:0]    s3_ang_reg;
    logic signed [COORD_W-1:0] s3_x_reg;
    logic signed [COORD_W-1:0] s3_y_reg;

    logic signed [PROD_W-1:0]  dist_ext;
    logic signed [PROD_W-1:0]  cos_ext;
    logic signed [PROD_W-1:0]  sin_ext;
    logic signed [PROD_W-1:0]  px_next;
    logic signed [PROD_W-1:0]  py_next;
    logic signed [COORD_W-1:0] x_next;
    logic signed [COORD_W-1:0] y_next;
    axis_t ax;
    axis_t ay;

    // credit: queue entries plus everything still in the pipe
    assign busy = {1'b0, q_cnt} + (MID_CW+1)'(s1_valid_reg)
                + (MID_CW+1)'(s2_valid_reg) + (MID_CW+1)'(s3_valid_reg);
    assign full   = (busy >= (MID_CW+1)'(MID_DEPTH));
    assign accept = push && !full;

    // trig tables, written and read at the request's angle
    pus_ram #(.WIDTH(TRIG_W), .DEPTH(MAX_ANGLES)) u_cos_ram (
        .clk   (clk),
        .we    (accept && (req_type == REQ_TRIG)),
        .waddr (angle_index),
        .wdata (cos_value),
        .raddr (angle_index),
        .rdata (cos_rdata)
    );

    pus_ram #(.WIDTH(TRIG_W), .DEPTH(MAX_ANGLES)) u_sin_ram (
        .clk   (clk),
        .we    (accept && (req_type == REQ_TRIG)),
        .waddr (angle_index),
        .wdata (sin_value),
        .raddr (angle_index),
        .rdata (sin_rdata)
    );

    // valid pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept && ((req_type == REQ_PIXEL) || (req_type == REQ_SAMPLE));
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // stage 1 capture
    always_ff @(posedge clk)
    begin
        s1_sample_reg <= (req_type == REQ_SAMPLE);
        s1_col_reg    <= pixel_col;
        s1_row_reg    <= pixel_row;
        s1_value_reg  <= pixel_value;
        s1_rad_reg    <= radius_index;
        s1_ang_reg    <= angle_index;
        s1_dist_reg   <= DIST_W'(radius_index) + DIST_W'(cfg.inner);
    end

    // distance times cosine / sine (Q.14)
    always_comb
    begin
        dist_ext = PROD_W'($signed({1'b0, s1_dist_reg}));
        cos_ext  = PROD_W'($signed(cos_rdata));
        sin_ext  = PROD_W'($signed(sin_rdata));
        px_next  = dist_ext * cos_ext;
        py_next  = dist_ext * sin_ext;
    end

    always_ff @(posedge clk)
    begin
        s2_sample_reg <= s1_sample_reg;
        s2_col_reg    <= s1_col_reg;
        s2_row_reg    <= s1_row_reg;
        s2_value_reg  <= s1_value_reg;
        s2_rad_reg    <= s1_rad_reg;
        s2_ang_reg    <= s1_ang_reg;
        s2_px_reg     <= px_next;
        s2_py_reg     <= py_next;
    end

    // floor to Q.8 and add center
    always_comb
    begin
        x_next = COORD_W'(s2_px_reg >>> TRIG_SHIFT)
               + COORD_W'($signed({1'b0, cfg.center_x}));
        y_next = COORD_W'(s2_py_reg >>> TRIG_SHIFT)
               + COORD_W'($signed({1'b0, cfg.center_y}));
    end

    always_ff @(posedge clk)
    begin
        s3_sample_reg <= s2_sample_reg;
        s3_col_reg    <= s2_col_reg;
        s3_row_reg    <= s2_row_reg;
        s3_value_reg  <= s2_value_reg;
        s3_rad_reg    <= s2_rad_reg;
        s3_ang_reg    <= s2_ang_reg;
        s3_x_reg      <= x_next;
        s3_y_reg      <= y_next;
    end

    // classify and hand to the queue
    always_comb
    begin
        ax = axis_map(s3_x_reg, cfg.width);
        ay = axis_map(s3_y_reg, cfg.height);
        q_data.is_sample = s3_sample_reg;
        q_data.value     = s3_value_reg;
        q_data.rad       = s3_rad_reg;
        q_data.ang       = s3_ang_reg;
        if (s3_sample_reg)
        begin
            q_data.col = ax.base[COL_W-1:0];
            q_data.row = ay.base[ROW_W-1:0];
            q_data.fx  = ax.frac;
            q_data.fy  = ay.frac;
        end
        else
        begin
            q_data.col = s3_col_reg;
            q_data.row = s3_row_reg;
            q_data.fx  = '0;
            q_data.fy  = '0;
        end
    end

    assign q_push = s3_valid_reg;

endmodule

[hw/rtl/pus_queue.sv]
// ----------------------------------------------------------------------------
// pus_queue
// Short register queue between the front and back ends.
// ----------------------------------------------------------------------------
module pus_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  pus_pkg::qentry_t           push_data,
    input  logic                       pop,
    output pus_pkg::qentry_t           head,
    output logic                       empty,
    output logic [pus_pkg::MID_CW-1:0] count
);
    import pus_pkg::*;

    qentry_t             mem_reg [MID_DEPTH];
    logic [MID_PW-1:0]   wr_ptr_reg;
    logic [MID_PW-1:0]   rd_ptr_reg;
    logic [MID_CW-1:0]   cnt_reg;
    logic [MID_CW-1:0]   cnt_next;

    // entry storage; the front never pushes past the credit limit
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg + MID_CW'(push) - MID_CW'(pop);
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + MID_PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + MID_PW'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign empty = (cnt_reg == '0);
    assign count = cnt_reg;

endmodule

[hw/rtl/pus_back.sv]
// ----------------------------------------------------------------------------
// pus_back
// Executes queued operations: pixel writes into the banked image store,
// four-neighbor reads and bilinear blend, then the result queue.
// ----------------------------------------------------------------------------
module pus_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_empty,
    input  pus_pkg::qentry_t          q_head,
    output logic                      q_pop,
    output logic                      empty,
    input  logic                      pop,
    output logic [pus_pkg::PIX_W-1:0] sample_value,
    output logic [pus_pkg::RAD_W-1:0] sample_radius,
    output logic [pus_pkg::ANG_W-1:0] sample_angle
);
    import pus_pkg::*;

    localparam int BANK_AW = (COL_W - 1) + (ROW_W - 1);

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic [RAD_W-1:0] rad;
        logic [ANG_W-1:0] ang;
    } result_t;

    logic              credit_ok;
    logic [OUT_CW:0]   out_busy;
    logic              do_write;
    logic [COL_W-1:0]  col_inc;
    logic [ROW_W-1:0]  row_inc;
    logic [PIX_W-1:0]  bank_rd [NUM_BANKS];

    // stage 1: RAM data arriving
    logic              s1_valid_reg;
    logic              s1_cpar_reg;
    logic              s1_rpar_reg;
    logic [FRAC_W-1:0] s1_fx_reg;
    logic [FRAC_W-1:0] s1_fy_reg;
    logic [RAD_W-1:0]  s1_rad_reg;
    logic [ANG_W-1:0]  s1_ang_reg;

    // stage 2: horizontal blends
    logic              s2_valid_reg;
    logic [LERP_W-1:0] s2_top_reg;
    logic [LERP_W-1:0] s2_bot_reg;
    logic [FRAC_W-1:0] s2_fy_reg;
    logic [RAD_W-1:0]  s2_rad_reg;
    logic [ANG_W-1:0]  s2_ang_reg;

    logic [PIX_W-1:0]  p00;
    logic [PIX_W-1:0]  p01;
    logic [PIX_W-1:0]  p10;
    logic [PIX_W-1:0]  p11;
    logic [LERP_W-1:0] top_next;
    logic [LERP_W-1:0] bot_next;
    logic [SUM_W-1:0]  sum;
    logic [SUM_W-Q8_SHIFT*2-1:0] val_wide;
    result_t           res_next;

    // result queue
    result_t           out_mem_reg [OUT_DEPTH];
    logic [OUT_PW-1:0] out_wr_reg;
    logic [OUT_PW-1:0] out_rd_reg;
    logic [OUT_CW-1:0] out_cnt_reg;
    logic              out_pop;

    // samples need a free result slot counting those in flight
    assign out_busy  = {1'b0, out_cnt_reg} + (OUT_CW+1)'(s1_valid_reg)
                     + (OUT_CW+1)'(s2_valid_reg);
    assign credit_ok = (out_busy < (OUT_CW+1)'(OUT_DEPTH));
    assign q_pop     = !q_empty && (!q_head.is_sample || credit_ok);
    assign do_write  = q_pop && !q_head.is_sample;

    // neighbor halves: the even index of the pair is (base+1)>>1
    assign col_inc = q_head.col + COL_W'(1);
    assign row_inc = q_head.row + ROW_W'(1);

    // image banks, selected by {row parity, column parity}
    for (genvar b = 0; b < NUM_BANKS; b++)
    begin : g_bank
        localparam int RP = b / 2;
        localparam int CP = b % 2;
        logic [BANK_AW-1:0] raddr;
        logic [BANK_AW-1:0] waddr;
        logic               we;
        logic [COL_W-2:0]   chalf;
        logic [ROW_W-2:0]   rhalf;

        always_comb
        begin
            chalf = (CP == 1) ? q_head.col[COL_W-1:1] : col_inc[COL_W-1:1];
            rhalf = (RP == 1) ? q_head.row[ROW_W-1:1] : row_inc[ROW_W-1:1];
            raddr = {rhalf, chalf};
            waddr = {q_head.row[ROW_W-1:1], q_head.col[COL_W-1:1]};
            we    = do_write && (q_head.row[0] == RP[0]) && (q_head.col[0] == CP[0]);
        end

        pus_ram #(.WIDTH(PIX_W), .DEPTH(BANK_DEPTH)) u_bank (
            .clk   (clk),
            .we    (we),
            .waddr (waddr),
            .wdata (q_head.value),
            .raddr (raddr),
            .rdata (bank_rd[b])
        );
    end

    // valid pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= q_pop && q_head.is_sample;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_cpar_reg <= q_head.col[0];
        s1_rpar_reg <= q_head.row[0];
        s1_fx_reg   <= q_head.fx;
        s1_fy_reg   <= q_head.fy;
        s1_rad_reg  <= q_head.rad;
        s1_ang_reg  <= q_head.ang;
    end

    // route bank data to neighbors and blend along x
    always_comb
    begin
        p00 = bank_rd[{s1_rpar_reg, s1_cpar_reg}];
        p01 = bank_rd[{s1_rpar_reg, !s1_cpar_reg}];
        p10 = bank_rd[{!s1_rpar_reg, s1_cpar_reg}];
        p11 = bank_rd[{!s1_rpar_reg, !s1_cpar_reg}];
        top_next = LERP_W'(p00) * LERP_W'(FRAC_ONE - s1_fx_reg)
                 + LERP_W'(p01) * LERP_W'(s1_fx_reg);
        bot_next = LERP_W'(p10) * LERP_W'(FRAC_ONE - s1_fx_reg)
                 + LERP_W'(p11) * LERP_W'(s1_fx_reg);
    end

    always_ff @(posedge clk)
    begin
        s2_top_reg <= top_next;
        s2_bot_reg <= bot_next;
        s2_fy_reg  <= s1_fy_reg;
        s2_rad_reg <= s1_rad_reg;
        s2_ang_reg <= s1_ang_reg;
    end

    // blend along y, drop the Q.16 fraction, saturate
    always_comb
    begin
        sum = SUM_W'(s2_top_reg) * SUM_W'(FRAC_ONE - s2_fy_reg)
            + SUM_W'(s2_bot_reg) * SUM_W'(s2_fy_reg);
        val_wide = sum[SUM_W-1:Q8_SHIFT*2];
        res_next.value = (val_wide > (SUM_W-Q8_SHIFT*2)'(PIX_MAX)) ?
                         PIX_MAX : val_wide[PIX_W-1:0];
        res_next.rad = s2_rad_reg;
        res_next.ang = s2_ang_reg;
    end

    // result queue storage
    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            out_mem_reg[out_wr_reg] <= res_next;
        end
    end

    assign out_pop = pop && (out_cnt_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_wr_reg  <= '0;
            out_rd_reg  <= '0;
            out_cnt_reg <= '0;
        end
        else
        begin
            if (s2_valid_reg)
            begin
                out_wr_reg <= out_wr_reg + OUT_PW'(1);
            end
            if (out_pop)
            begin
                out_rd_reg <= out_rd_reg + OUT_PW'(1);
            end
            out_cnt_reg <= out_cnt_reg + OUT_CW'(s2_valid_reg) - OUT_CW'(out_pop);
        end
    end

    assign empty         = (out_cnt_reg == '0);
    assign sample_value  = out_mem_reg[out_rd_reg].value;
    assign sample_radius = out_mem_reg[out_rd_reg].rad;
    assign sample_angle  = out_mem_reg[out_rd_reg].ang;

endmodule

[hw/rtl/polar_unwarp_bilinear_sampler_core.sv]
// ----------------------------------------------------------------------------
// polar_unwarp_bilinear_sampler_core
// Polar-to-image bilinear sampler with banked image store and trig tables.
// ----------------------------------------------------------------------------
// Takes one request per clock while full is low, whatever its type: pixel
// writes, trig table writes and sample requests mix freely and act in order.
// A sample request's result shows on the result ports once the request has
// passed the three front stages, the queue and the two back stages into the
// result queue; writes give none. full rises only when the receiver holds
// results back and the queues fill. The rate is set by the image store,
// split into four banks by row and column parity so the four neighbors
// come out of one read. Image and trig stores are not cleared by reset:
// every entry that a sample touches must have been written first, and
// there is no clearing pass after reset.
// Configuration is a plain register write the user makes only while idle; unchecked.
// ----------------------------------------------------------------------------
module polar_unwarp_bilinear_sampler_core (
    input  logic                           clk,
    input  logic                           rst_n,
    // request side
    input  logic                           push,
    output logic                           full,
    input  logic [pus_pkg::REQ_W-1:0]      req_type,
    input  logic [pus_pkg::COL_W-1:0]      pixel_col,
    input  logic [pus_pkg::ROW_W-1:0]      pixel_row,
    input  logic [pus_pkg::PIX_W-1:0]      pixel_value,
    input  logic [pus_pkg::ANG_W-1:0]      angle_index,
    input  logic signed [pus_pkg::TRIG_W-1:0] cos_value,
    input  logic signed [pus_pkg::TRIG_W-1:0] sin_value,
    input  logic [pus_pkg::RAD_W-1:0]      radius_index,
    // result side
    output logic                           empty,
    input  logic                           pop,
    output logic [pus_pkg::PIX_W-1:0]      sample_value,
    output logic [pus_pkg::RAD_W-1:0]      sample_radius,
    output logic [pus_pkg::ANG_W-1:0]      sample_angle,
    // configuration
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pus_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pus_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pus_pkg::*;

    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic [CTR_W-1:0]  center_x_reg;
    logic [CTR_W-1:0]  center_y_reg;
    logic [RAD_W-1:0]  inner_reg;
    cfg_t              cfg;

    logic              q_push;
    qentry_t           q_push_data;
    logic              q_pop;
    qentry_t           q_head;
    logic              q_empty;
    logic [MID_CW-1:0] q_cnt;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= SIZE_RESET;
            height_reg   <= SIZE_RESET;
            center_x_reg <= '0;
            center_y_reg <= '0;
            inner_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg    <= cfg_data[SIZE_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg   <= cfg_data[SIZE_W-1:0];
                CFG_CENTER_X:     center_x_reg <= cfg_data[CTR_W-1:0];
                CFG_CENTER_Y:     center_y_reg <= cfg_data[CTR_W-1:0];
                CFG_INNER_RADIUS: inner_reg    <= cfg_data[RAD_W-1:0];
                default:          ;
            endcase
        end
    end

    // effective sizes clamped to the store
    always_comb
    begin
        if (width_reg < SIZE_W'(2))
            cfg.width = SIZE_W'(2);
        else if (width_reg > SIZE_W'(MAX_WIDTH))
            cfg.width = SIZE_W'(MAX_WIDTH);
        else
            cfg.width = width_reg;
        if (height_reg < SIZE_W'(2))
            cfg.height = SIZE_W'(2);
        else if (height_reg > SIZE_W'(MAX_HEIGHT))
            cfg.height = SIZE_W'(MAX_HEIGHT);
        else
            cfg.height = height_reg;
        cfg.center_x = center_x_reg;
        cfg.center_y = center_y_reg;
        cfg.inner    = inner_reg;
    end

    pus_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .req_type     (req_type),
        .pixel_col    (pixel_col),
        .pixel_row    (pixel_row),
        .pixel_value  (pixel_value),
        .angle_index  (angle_index),
        .cos_value    (cos_value),
        .sin_value    (sin_value),
        .radius_index (radius_index),
        .cfg          (cfg),
        .q_cnt        (q_cnt),
        .q_push       (q_push),
        .q_data       (q_push_data)
    );

    pus_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .count     (q_cnt)
    );

    pus_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .empty         (empty),
        .pop           (pop),
        .sample_value  (sample_value),
        .sample_radius (sample_radius),
        .sample_angle  (sample_angle)
    );

endmodule

[hw/rtl/pus_checker.sv]
// ----------------------------------------------------------------------------
// pus_checker
// Port-level checks of the sampler, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pus_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  logic                           full,
    input  logic [pus_pkg::REQ_W-1:0]      req_type,
    input  logic                           empty,
    input  logic                           pop,
    input  logic [pus_pkg::PIX_W-1:0]      sample_value,
    input  logic [pus_pkg::RAD_W-1:0]      sample_radius,
    input  logic [pus_pkg::ANG_W-1:0]      sample_angle
);
    import pus_pkg::*;

    localparam int PEND_W = 6;

    logic [PEND_W-1:0] pending_reg;
    logic [PEND_W-1:0] pending_next;
    logic              sample_in;
    logic              result_out;

    // sample requests taken but not yet delivered
    assign sample_in  = push && !full && (req_type == REQ_SAMPLE);
    assign result_out = pop && !empty;

    always_comb
    begin
        pending_next = pending_reg + PEND_W'(sample_in) - PEND_W'(result_out);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // a result is only ever shown for an outstanding sample request
    `ASSERT_IMPLY(a_no_spurious_result, clk, rst_n, !empty, pending_reg != '0)

    // a waiting result holds until taken
    `ASSERT_NEXT(a_result_holds, clk, rst_n, !empty && !pop, !empty && $stable(sample_value) && $stable(sample_radius) && $stable(sample_angle))

    // no result is pending out of reset
    `ASSERT_IN_RESET(a_reset_empty, clk, rst_n, empty)

endmodule

bind polar_unwarp_bilinear_sampler_core pus_checker u_pus_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .req_type      (req_type),
    .empty         (empty),
    .pop           (pop),
    .sample_value  (sample_value),
    .sample_radius (sample_radius),
    .sample_angle  (sample_angle)
);
